@@ rtl/bsc_pkg.sv @@
// Shared types and constants for the barometric sensor compensation pipeline.
// No dependencies; imported by bsc_div and the top level.
`default_nettype none

package bsc_pkg;

    // width of the pressure divide
    localparam int DIV_W = 64;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP      = 3'd0;
    localparam logic [2:0] CFG_PRESS_LO  = 3'd1;
    localparam logic [2:0] CFG_PRESS_HI  = 3'd2;
    localparam logic [2:0] CFG_MIXED     = 3'd3;
    localparam logic [2:0] CFG_HUM       = 3'd4;
    localparam logic [2:0] CFG_HUM_EN    = 3'd5;

    // compensation constants
    localparam logic signed [32:0] P_FINE_OFS = 33'sd128000;
    localparam logic [31:0]        H_FINE_OFS = 32'd76800;
    localparam logic [20:0]        P_RAW_FULL = 21'd1048576;
    localparam logic [11:0]        P_SCALE    = 12'd3125;
    localparam logic [63:0]        P_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        H_ROUND_A  = 32'd16384;
    localparam logic signed [31:0] H_OFS_T    = 32'sd32768;
    localparam logic signed [31:0] H_OFS_B    = 32'sd2097152;
    localparam logic signed [31:0] H_ROUND_B  = 32'sd8192;
    localparam logic [31:0]        H_CLAMP    = 32'd419430400;
    localparam logic [16:0]        H_MAX_OUT  = 17'd102400;

    // results that ride alongside the pressure path
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
    } t_side;

    typedef struct packed {
        t_side res;
        logic  neg;
        logic  dz;
    } t_dside;

    localparam int DIV_SIDE_W = $bits(t_dside);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] press;
        logic [16:0] hum;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/bsc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bsc_pkg (DIV_W, DIV_SIDE_W).
`default_nettype none

module bsc_div #(
    parameter int SIDE_W = bsc_pkg::DIV_SIDE_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [bsc_pkg::DIV_W-1:0]  i_num,
    input  wire logic [bsc_pkg::DIV_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_vld,
    output logic [bsc_pkg::DIV_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]               o_side
);
    import bsc_pkg::*;

    // partial remainder and divisor are not needed after the last stage
    logic [DIV_W-1:0]  r_rem  [1:DIV_W-1];
    logic [DIV_W-1:0]  r_den  [1:DIV_W-1];
    // top: dividend bits still to consume, bottom: quotient bits so far
    logic [DIV_W-1:0]  r_acc  [1:DIV_W];
    logic [SIDE_W-1:0] r_side [1:DIV_W];
    logic [DIV_W:1]    r_vld;

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0]  w_rem_in;
        logic [DIV_W-1:0]  w_acc_in;
        logic [DIV_W-1:0]  w_den_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [DIV_W:0]    w_trial;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_acc_in  = i_num;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[k];
            assign w_acc_in  = r_acc[k];
            assign w_den_in  = r_den[k];
            assign w_side_in = r_side[k];
        end

        assign w_trial = {w_rem_in, w_acc_in[DIV_W-1]} - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1]  <= {w_acc_in[DIV_W-2:0], ~w_trial[DIV_W]};
                r_side[k+1] <= w_side_in;
            end
        end

        if (k < DIV_W-1) begin : g_rem
            // remainder stays below the divisor, so its top bit is clear
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_trial[DIV_W] ?
                                  {w_rem_in[DIV_W-2:0], w_acc_in[DIV_W-1]} :
                                  w_trial[DIV_W-1:0];
                    r_den[k+1] <= w_den_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_W-1:1], i_vld};
        end
    end

    assign o_vld  = r_vld[DIV_W];
    assign o_quo  = r_acc[DIV_W];
    assign o_side = r_side[DIV_W];

endmodule

`default_nettype wire

@@ rtl/barometric_sensor_compensation.sv @@
// Top level: integer temperature / pressure / humidity compensation pipeline.
// Depends on bsc_pkg and bsc_div.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_raw_*            | sample in
//  out     | o_out_valid, i_out_ready, o_*              | result out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data            | write only
//
// One sample set per cycle while the output buffer has room; a result passes through
// 13 front stages, 64 divider stages, 6 pressure stages and the output buffer
// before it can transfer out.
// The 64-stage pipelined divide sets the latency.
// Synchronous active-low reset clears valid bits, buffer count and pointers, and coefficients.
// A two-entry output buffer holds results while the sink stalls; the whole
// pipeline freezes only when both entries are full.
`default_nettype none

module barometric_sensor_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [19:0]        i_raw_temperature,
    input  wire logic [19:0]        i_raw_pressure,
    input  wire logic [15:0]        i_raw_humidity,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_temperature_centi,
    output logic signed [31:0]      o_fine_temperature,
    output logic [31:0]             o_pressure_q24_8,
    output logic [16:0]             o_humidity_q22_10,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [63:0]        i_cfg_data
);
    import bsc_pkg::*;

    // ---------------- configuration ----------------
    logic [47:0] r_cfg_temp;
    logic [63:0] r_cfg_plo;
    logic [63:0] r_cfg_phi;
    logic [47:0] r_cfg_mix;
    logic [31:0] r_cfg_hum;
    logic        r_cfg_hen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp <= '0;
            r_cfg_plo  <= '0;
            r_cfg_phi  <= '0;
            r_cfg_mix  <= '0;
            r_cfg_hum  <= '0;
            r_cfg_hen  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:     r_cfg_temp <= i_cfg_data[47:0];
                CFG_PRESS_LO: r_cfg_plo  <= i_cfg_data;
                CFG_PRESS_HI: r_cfg_phi  <= i_cfg_data;
                CFG_MIXED:    r_cfg_mix  <= i_cfg_data[47:0];
                CFG_HUM:      r_cfg_hum  <= i_cfg_data[31:0];
                CFG_HUM_EN:   r_cfg_hen  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3;
    logic signed [15:0] w_h2;
    logic [11:0]        w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_cfg_temp[15:0];
    assign w_t2 = r_cfg_temp[31:16];
    assign w_t3 = r_cfg_temp[47:32];
    assign w_p1 = r_cfg_plo[15:0];
    assign w_p2 = r_cfg_plo[31:16];
    assign w_p3 = r_cfg_plo[47:32];
    assign w_p4 = r_cfg_plo[63:48];
    assign w_p5 = r_cfg_phi[15:0];
    assign w_p6 = r_cfg_phi[31:16];
    assign w_p7 = r_cfg_phi[47:32];
    assign w_p8 = r_cfg_phi[63:48];
    assign w_p9 = r_cfg_mix[15:0];
    assign w_h1 = r_cfg_mix[23:16];
    assign w_h2 = r_cfg_mix[39:24];
    assign w_h3 = r_cfg_mix[47:40];
    assign w_h4 = r_cfg_hum[11:0];
    assign w_h5 = r_cfg_hum[23:12];
    assign w_h6 = r_cfg_hum[31:24];

    // ---------------- flow control ----------------
    logic        w_en;
    logic [13:1] r_vpre;
    logic [19:14] r_vpost;
    logic        w_div_vld;
    logic [1:0]  r_cnt;
    logic        r_wp, r_rp;
    t_out        r_fifo [0:1];
    logic        w_push, w_pop;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;
    assign w_push     = w_en && r_vpost[19];
    assign w_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre  <= '0;
            r_vpost <= '0;
        end else if (w_en) begin
            r_vpre  <= {r_vpre[12:1], i_in_valid};
            r_vpost <= {r_vpost[18:14], w_div_vld};
        end
    end

    // ---------------- datapath registers ----------------
    logic signed [17:0] r_s1_ta;
    logic signed [16:0] r_s1_tb;
    logic [19:0]        r_s1_rp, r_s2_rp, r_s3_rp, r_s4_rp;
    logic [15:0]        r_s1_rh, r_s2_rh, r_s3_rh, r_s4_rh, r_s5_rh, r_s6_rh;
    logic signed [31:0] r_s2_m1;
    logic [31:0]        r_s2_m2;
    logic signed [31:0] r_s3_v1, r_s3_m3;
    logic signed [31:0] r_s4_fine;
    logic [63:0]        r_s5_tf, r_s6_tf, r_s7_tf, r_s8_tf, r_s9_tf, r_s10_tf;
    logic [63:0]        r_s11_tf, r_s12_tf;
    logic signed [32:0] r_s5_pv1;
    logic [20:0]        r_s5_pd, r_s6_pd, r_s7_pd, r_s8_pd, r_s9_pd;
    logic [31:0]        r_s5_hx;
    logic [63:0]        r_s6_sq;
    logic signed [48:0] r_s6_v1p5, r_s6_v1p2, r_s7_v1p5, r_s7_v1p2, r_s8_v1p5, r_s8_v1p2;
    logic [31:0]        r_s6_hm1, r_s6_hm2, r_s6_hm3;
    logic signed [48:0] r_s7_s6l, r_s7_s3l;
    logic [31:0]        r_s7_s6h, r_s7_s3h;
    logic signed [31:0] r_s7_ha, r_s7_hb1, r_s7_ht, r_s8_ha, r_s9_ha;
    logic [63:0]        r_s8_v2a, r_s8_x3;
    logic [31:0]        r_s8_hbb;
    logic [63:0]        r_s9_v2, r_s9_v1b;
    logic [31:0]        r_s9_hm;
    logic [63:0]        r_s10_w, r_s10_n0;
    logic [31:0]        r_s10_hx2, r_s11_hx2, r_s12_hx2;
    logic [47:0]        r_s11_wl;
    logic [31:0]        r_s11_wh, r_s11_nh, r_s11_hcc;
    logic [43:0]        r_s11_nl;
    logic [63:0]        r_s12_den, r_s12_num;
    logic [31:0]        r_s12_hd;
    t_dside             r_s13_ds;
    logic [63:0]        r_s13_an, r_s13_ad;
    logic [63:0]        r_s14_p, r_s15_p, r_s16_p, r_s17_p, r_s18_p;
    t_side              r_s14_res, r_s15_res, r_s16_res, r_s17_res, r_s18_res, r_s19_res;
    logic               r_s14_dz, r_s15_dz, r_s16_dz, r_s17_dz, r_s18_dz;
    logic [63:0]        r_s15_qll;
    logic [31:0]        r_s15_qlh, r_s15_p8h;
    logic signed [48:0] r_s15_p8l;
    logic [63:0]        r_s16_qq, r_s16_v2, r_s17_v2, r_s18_v2, r_s18_v1;
    logic signed [48:0] r_s17_s9l;
    logic [31:0]        r_s17_s9h;
    logic [31:0]        r_s19_p;

    // ---------------- combinational pieces ----------------
    logic signed [17:0] w_ta;
    logic signed [16:0] w_tb;
    logic signed [33:0] w_m1, w_m2;
    logic signed [31:0] w_m2s;
    logic signed [47:0] w_m3;
    logic signed [31:0] w_t5, w_tc;
    logic signed [65:0] w_sq;
    logic signed [48:0] w_v1p5, w_v1p2;
    logic [43:0]        w_h5x;
    logic signed [39:0] w_xh6;
    logic [39:0]        w_xh3;
    logic signed [48:0] w_s6l, w_s3l;
    logic signed [47:0] w_s6h, w_s3h;
    logic [31:0]        w_ha;
    logic [63:0]        w_hbb;
    logic signed [63:0] w_x3sh;
    logic signed [31:0] w_hb2, w_hb3;
    logic signed [47:0] w_hm;
    logic [63:0]        w_hx2;
    logic [47:0]        w_wl, w_wh;
    logic [43:0]        w_nl, w_nh;
    logic signed [31:0] w_hc, w_hcs, w_hds;
    logic [63:0]        w_hcc;
    logic [63:0]        w_den_raw;
    logic signed [63:0] w_den;
    logic signed [40:0] w_hd;
    logic [31:0]        w_hy;
    logic [16:0]        w_hum;
    t_dside             w_ds;
    logic [63:0]        w_div_quo;
    t_dside             w_div_ds;
    logic signed [63:0] w_q13;
    logic [63:0]        w_qll, w_qlh;
    logic signed [48:0] w_p8l, w_s9l;
    logic signed [47:0] w_p8h, w_s9h;
    logic [63:0]        w_v2raw, w_v1raw, w_psum;
    logic signed [63:0] w_v2sh, w_v1sh, w_psh;
    logic [31:0]        w_pout;

    // temperature
    assign w_ta  = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_tb  = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, w_t1});
    assign w_m1  = r_s1_ta * w_t2;
    assign w_m2  = r_s1_tb * r_s1_tb;
    assign w_m2s = $signed(r_s2_m2) >>> 12;
    assign w_m3  = w_m2s * w_t3;
    assign w_t5  = r_s4_fine + (r_s4_fine <<< 2) + 32'sd128;
    assign w_tc  = w_t5 >>> 8;

    // pressure front end
    assign w_sq   = r_s5_pv1 * r_s5_pv1;
    assign w_v1p5 = r_s5_pv1 * w_p5;
    assign w_v1p2 = r_s5_pv1 * w_p2;
    assign w_s6l  = $signed({1'b0, r_s6_sq[31:0]}) * w_p6;
    assign w_s6h  = $signed(r_s6_sq[63:32]) * w_p6;
    assign w_s3l  = $signed({1'b0, r_s6_sq[31:0]}) * w_p3;
    assign w_s3h  = $signed(r_s6_sq[63:32]) * w_p3;
    assign w_x3sh = $signed(r_s8_x3) >>> 8;
    assign w_wl   = r_s10_w[31:0] * w_p1;
    assign w_wh   = r_s10_w[63:32] * w_p1;
    assign w_nl   = r_s10_n0[31:0] * P_SCALE;
    assign w_nh   = r_s10_n0[63:32] * P_SCALE;
    assign w_den_raw = {16'd0, r_s11_wl} + {r_s11_wh, 32'd0};
    assign w_den     = $signed(w_den_raw) >>> 33;

    // humidity
    assign w_h5x = r_s5_hx * w_h5;
    assign w_xh6 = $signed(r_s5_hx) * w_h6;
    assign w_xh3 = r_s5_hx * w_h3;
    assign w_ha  = {2'b00, r_s6_rh, 14'd0} - {w_h4, 20'd0} - r_s6_hm1 + H_ROUND_A;
    assign w_hbb = r_s7_hb1 * r_s7_ht;
    assign w_hb2 = ($signed(r_s8_hbb) >>> 10) + H_OFS_B;
    assign w_hm  = w_hb2 * w_h2;
    assign w_hb3 = ($signed(r_s9_hm) + H_ROUND_B) >>> 14;
    assign w_hx2 = r_s9_ha * w_hb3;
    assign w_hc  = $signed(r_s10_hx2) >>> 15;
    assign w_hcc = w_hc * w_hc;
    assign w_hcs = $signed(r_s11_hcc) >>> 7;
    assign w_hd  = w_hcs * $signed({1'b0, w_h1});
    assign w_hds = $signed(r_s12_hd) >>> 4;
    assign w_hy  = r_s12_hx2 - w_hds;

    always_comb begin
        if (w_hy[31]) begin
            w_hum = '0;
        end else if (w_hy > H_CLAMP) begin
            w_hum = H_MAX_OUT;
        end else begin
            w_hum = w_hy[28:12];
        end
        w_ds.res.temp = r_s12_tf[63:32];
        w_ds.res.fine = r_s12_tf[31:0];
        w_ds.res.hum  = r_cfg_hen ? w_hum : 17'd0;
        w_ds.neg      = r_s12_num[63] ^ r_s12_den[63];
        w_ds.dz       = (r_s12_den == 64'd0);
    end

    // pressure back end
    assign w_q13   = $signed(r_s14_p) >>> 13;
    assign w_qll   = w_q13[31:0] * w_q13[31:0];
    assign w_qlh   = w_q13[31:0] * w_q13[63:32];
    assign w_p8l   = $signed({1'b0, r_s14_p[31:0]}) * w_p8;
    assign w_p8h   = $signed(r_s14_p[63:32]) * w_p8;
    assign w_v2raw = {{15{r_s15_p8l[48]}}, r_s15_p8l} + {r_s15_p8h, 32'd0};
    assign w_v2sh  = $signed(w_v2raw) >>> 19;
    assign w_s9l   = $signed({1'b0, r_s16_qq[31:0]}) * w_p9;
    assign w_s9h   = $signed(r_s16_qq[63:32]) * w_p9;
    assign w_v1raw = {{15{r_s17_s9l[48]}}, r_s17_s9l} + {r_s17_s9h, 32'd0};
    assign w_v1sh  = $signed(w_v1raw) >>> 25;
    assign w_psum  = r_s18_p + r_s18_v1 + r_s18_v2;
    assign w_psh   = $signed(w_psum) >>> 8;
    assign w_pout  = w_psh[31:0] + {{12{w_p7[15]}}, w_p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1
            r_s1_ta <= w_ta;
            r_s1_tb <= w_tb;
            r_s1_rp <= i_raw_pressure;
            r_s1_rh <= i_raw_humidity;
            // stage 2
            r_s2_m1 <= w_m1[31:0];
            r_s2_m2 <= w_m2[31:0];
            r_s2_rp <= r_s1_rp;
            r_s2_rh <= r_s1_rh;
            // stage 3
            r_s3_v1 <= r_s2_m1 >>> 11;
            r_s3_m3 <= w_m3[31:0];
            r_s3_rp <= r_s2_rp;
            r_s3_rh <= r_s2_rh;
            // stage 4: fine temperature
            r_s4_fine <= r_s3_v1 + (r_s3_m3 >>> 14);
            r_s4_rp   <= r_s3_rp;
            r_s4_rh   <= r_s3_rh;
            // stage 5
            r_s5_tf  <= {w_tc, r_s4_fine};
            r_s5_pv1 <= {r_s4_fine[31], r_s4_fine} - P_FINE_OFS;
            r_s5_pd  <= P_RAW_FULL - {1'b0, r_s4_rp};
            r_s5_hx  <= r_s4_fine - H_FINE_OFS;
            r_s5_rh  <= r_s4_rh;
            // stage 6
            r_s6_tf   <= r_s5_tf;
            r_s6_sq   <= w_sq[63:0];
            r_s6_v1p5 <= w_v1p5;
            r_s6_v1p2 <= w_v1p2;
            r_s6_pd   <= r_s5_pd;
            r_s6_hm1  <= w_h5x[31:0];
            r_s6_hm2  <= w_xh6[31:0];
            r_s6_hm3  <= w_xh3[31:0];
            r_s6_rh   <= r_s5_rh;
            // stage 7
            r_s7_tf   <= r_s6_tf;
            r_s7_s6l  <= w_s6l;
            r_s7_s6h  <= w_s6h[31:0];
            r_s7_s3l  <= w_s3l;
            r_s7_s3h  <= w_s3h[31:0];
            r_s7_v1p5 <= r_s6_v1p5;
            r_s7_v1p2 <= r_s6_v1p2;
            r_s7_pd   <= r_s6_pd;
            r_s7_ha   <= $signed(w_ha) >>> 15;
            r_s7_hb1  <= $signed(r_s6_hm2) >>> 10;
            r_s7_ht   <= ($signed(r_s6_hm3) >>> 11) + H_OFS_T;
            // stage 8
            r_s8_tf   <= r_s7_tf;
            r_s8_v2a  <= {{15{r_s7_s6l[48]}}, r_s7_s6l} + {r_s7_s6h, 32'd0};
            r_s8_x3   <= {{15{r_s7_s3l[48]}}, r_s7_s3l} + {r_s7_s3h, 32'd0};
            r_s8_v1p5 <= r_s7_v1p5;
            r_s8_v1p2 <= r_s7_v1p2;
            r_s8_pd   <= r_s7_pd;
            r_s8_ha   <= r_s7_ha;
            r_s8_hbb  <= w_hbb[31:0];
            // stage 9
            r_s9_tf  <= r_s8_tf;
            r_s9_v2  <= r_s8_v2a + ({{15{r_s8_v1p5[48]}}, r_s8_v1p5} << 17)
                        + ({{48{w_p4[15]}}, w_p4} << 35);
            r_s9_v1b <= w_x3sh + ({{15{r_s8_v1p2[48]}}, r_s8_v1p2} << 12);
            r_s9_pd  <= r_s8_pd;
            r_s9_ha  <= r_s8_ha;
            r_s9_hm  <= w_hm[31:0];
            // stage 10
            r_s10_tf  <= r_s9_tf;
            r_s10_w   <= P_BIAS + r_s9_v1b;
            r_s10_n0  <= {12'd0, r_s9_pd, 31'd0} - r_s9_v2;
            r_s10_hx2 <= w_hx2[31:0];
            // stage 11
            r_s11_tf  <= r_s10_tf;
            r_s11_wl  <= w_wl;
            r_s11_wh  <= w_wh[31:0];
            r_s11_nl  <= w_nl;
            r_s11_nh  <= w_nh[31:0];
            r_s11_hcc <= w_hcc[31:0];
            r_s11_hx2 <= r_s10_hx2;
            // stage 12
            r_s12_tf  <= r_s11_tf;
            r_s12_den <= w_den;
            r_s12_num <= {20'd0, r_s11_nl} + {r_s11_nh, 32'd0};
            r_s12_hd  <= w_hd[31:0];
            r_s12_hx2 <= r_s11_hx2;
            // stage 13: magnitudes for the divide
            r_s13_ds <= w_ds;
            r_s13_an <= r_s12_num[63] ? (64'd0 - r_s12_num) : r_s12_num;
            r_s13_ad <= r_s12_den[63] ? (64'd0 - r_s12_den) : r_s12_den;
            // stage 14: signed quotient
            r_s14_p   <= w_div_ds.neg ? (64'd0 - w_div_quo) : w_div_quo;
            r_s14_res <= w_div_ds.res;
            r_s14_dz  <= w_div_ds.dz;
            // stage 15
            r_s15_p   <= r_s14_p;
            r_s15_qll <= w_qll;
            r_s15_qlh <= w_qlh[31:0];
            r_s15_p8l <= w_p8l;
            r_s15_p8h <= w_p8h[31:0];
            r_s15_res <= r_s14_res;
            r_s15_dz  <= r_s14_dz;
            // stage 16: square of the scaled pressure, low 64 bits
            r_s16_p   <= r_s15_p;
            r_s16_qq  <= r_s15_qll + {r_s15_qlh[30:0], 33'd0};
            r_s16_v2  <= w_v2sh;
            r_s16_res <= r_s15_res;
            r_s16_dz  <= r_s15_dz;
            // stage 17
            r_s17_p   <= r_s16_p;
            r_s17_s9l <= w_s9l;
            r_s17_s9h <= w_s9h[31:0];
            r_s17_v2  <= r_s16_v2;
            r_s17_res <= r_s16_res;
            r_s17_dz  <= r_s16_dz;
            // stage 18
            r_s18_p   <= r_s17_p;
            r_s18_v1  <= w_v1sh;
            r_s18_v2  <= r_s17_v2;
            r_s18_res <= r_s17_res;
            r_s18_dz  <= r_s17_dz;
            // stage 19: zero divisor forces the whole pressure to zero
            r_s19_p   <= r_s18_dz ? 32'd0 : w_pout;
            r_s19_res <= r_s18_res;
        end
    end

    bsc_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vpre[13]),
        .i_num   (r_s13_an),
        .i_den   (r_s13_ad),
        .i_side  (r_s13_ds),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_ds)
    );

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= '{temp:  r_s19_res.temp,
                              fine:  r_s19_res.fine,
                              press: r_s19_p,
                              hum:   r_s19_res.hum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out_valid         = (r_cnt != 2'd0);
    assign o_temperature_centi = r_fifo[r_rp].temp;
    assign o_fine_temperature  = r_fifo[r_rp].fine;
    assign o_pressure_q24_8    = r_fifo[r_rp].press;
    assign o_humidity_q22_10   = r_fifo[r_rp].hum;

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_vpost[19]) |=> r_vpost[19])
        else $error("last stage lost its item during a stall");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && r_cnt == 2'd1) |=> (r_cnt == 2'd2 && !o_in_ready))
        else $error("buffer did not fill and stall the pipeline");

    a_div_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_div_vld) |=> w_div_vld)
        else $error("divider output lost during a stall");

endmodule

`default_nettype wire
